>>> design/y2r_pkg.sv
// y2r_pkg: shared types, constants and chroma term function for the yuyv to rgb565 converter
// no dependencies
`default_nettype none

package y2r_pkg;

  localparam int BYTE_W  = 8;
  localparam int PIX_W   = 16;
  localparam int TERM_W  = 10;
  localparam int SUM_W   = 11;

  localparam int CHROMA_MID = 128;
  localparam int CHAN_MAX   = 255;
  localparam int COEF_RV    = 1402;
  localparam int COEF_GU    = 344;
  localparam int COEF_GV    = 714;
  localparam int COEF_BU    = 1772;
  localparam int COEF_SCALE = 1000;

  // x / 1000 == (x * ceil(2^28 / 1000)) >> 28 for every x up to 128 * 1772
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP       = ((2 ** RECIP_SHIFT) + COEF_SCALE - 1) / COEF_SCALE;
  localparam int KC_W        = 29;
  localparam int PROD_W      = BYTE_W + KC_W;

  localparam logic [KC_W-1:0] KC_RV = KC_W'(COEF_RV * RECIP);
  localparam logic [KC_W-1:0] KC_GU = KC_W'(COEF_GU * RECIP);
  localparam logic [KC_W-1:0] KC_GV = KC_W'(COEF_GV * RECIP);
  localparam logic [KC_W-1:0] KC_BU = KC_W'(COEF_BU * RECIP);

  typedef logic signed [TERM_W-1:0] term_t;

  typedef struct packed {
    term_t red;
    term_t green;
    term_t blue;
  } chroma_terms_t;

  // signed offset times coefficient over 1000, truncated toward zero
  function automatic term_t chroma_term(input logic [BYTE_W-1:0] code,
                                        input logic [KC_W-1:0] kc,
                                        input logic flip);
    logic signed [BYTE_W:0] off;
    logic [BYTE_W-1:0]      mag;
    logic [PROD_W-1:0]      prod;
    logic [BYTE_W-1:0]      q;
    off = $signed({1'b0, code}) - $signed((BYTE_W+1)'(CHROMA_MID));
    if (flip) begin
      off = -off;
    end
    mag  = off[BYTE_W] ? BYTE_W'(-off) : off[BYTE_W-1:0];
    prod = PROD_W'(mag) * PROD_W'(kc);
    q    = prod[RECIP_SHIFT +: BYTE_W];
    return off[BYTE_W] ? -$signed(TERM_W'(q)) : $signed(TERM_W'(q));
  endfunction

endpackage

`default_nettype wire

>>> design/yuyv_to_rgb565_converter.sv
// yuyv_to_rgb565_converter: top level, shared chroma stage, two pixel lanes, output merge
// depends on y2r_pkg, y2r_chroma, y2r_lane
// path: an accepted word is held in the chroma stage registers, then in the output registers that drive the out_ ports
// throughput: one word per cycle, busy stays low; two registered stages (chroma, output)
// reset: synchronous active-low rst_n clears the stage valid and out_strobe
// the receiver cannot stall: each result shows for exactly one cycle
`default_nettype none

module yuyv_to_rgb565_converter (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [y2r_pkg::BYTE_W-1:0]  in_luma_first,
  input  wire logic [y2r_pkg::BYTE_W-1:0]  in_chroma_blue,
  input  wire logic [y2r_pkg::BYTE_W-1:0]  in_luma_second,
  input  wire logic [y2r_pkg::BYTE_W-1:0]  in_chroma_red,
  input  wire logic                        in_frame_end,
  output logic                             out_strobe,
  output logic [y2r_pkg::PIX_W-1:0]        out_pixel_first,
  output logic [y2r_pkg::PIX_W-1:0]        out_pixel_second,
  output logic                             out_frame_end_out
);

  logic                        accept;
  logic                        s1_valid_r;
  logic [y2r_pkg::BYTE_W-1:0]  s1_luma0_r;
  logic [y2r_pkg::BYTE_W-1:0]  s1_luma1_r;
  logic                        s1_fe_r;
  y2r_pkg::chroma_terms_t      s1_terms;
  logic [y2r_pkg::PIX_W-1:0]   lane_pix0;
  logic [y2r_pkg::PIX_W-1:0]   lane_pix1;
  logic                        out_strobe_r;
  logic [y2r_pkg::PIX_W-1:0]   out_pix0_r;
  logic [y2r_pkg::PIX_W-1:0]   out_pix1_r;
  logic                        out_fe_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  y2r_chroma u_chroma (
    .clk         (clk),
    .chroma_blue (in_chroma_blue),
    .chroma_red  (in_chroma_red),
    .terms       (s1_terms)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_luma0_r <= in_luma_first;
    s1_luma1_r <= in_luma_second;
    s1_fe_r    <= in_frame_end;
  end

  y2r_lane u_lane0 (
    .luma  (s1_luma0_r),
    .terms (s1_terms),
    .pixel (lane_pix0)
  );

  y2r_lane u_lane1 (
    .luma  (s1_luma1_r),
    .terms (s1_terms),
    .pixel (lane_pix1)
  );

  // merge both lanes into one result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_pix0_r <= lane_pix0;
    out_pix1_r <= lane_pix1;
    out_fe_r   <= s1_fe_r;
  end

  assign out_strobe        = out_strobe_r;
  assign out_pixel_first   = out_pix0_r;
  assign out_pixel_second  = out_pix1_r;
  assign out_frame_end_out = out_fe_r;

  a_accept_to_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_strobe)
    else $error("accepted word produced no result");

  a_strobe_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 2))
    else $error("result without accepted word");

  a_frame_end_passes: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_frame_end_out == $past(in_frame_end, 2)))
    else $error("frame end mark mismatch");

endmodule

`default_nettype wire

>>> design/y2r_chroma.sv
// y2r_chroma: shared chroma stage, computes the red, green and blue terms from U and V
// depends on y2r_pkg
`default_nettype none

module y2r_chroma (
  input  wire logic                          clk,
  input  wire logic [y2r_pkg::BYTE_W-1:0]    chroma_blue,
  input  wire logic [y2r_pkg::BYTE_W-1:0]    chroma_red,
  output y2r_pkg::chroma_terms_t             terms
);

  y2r_pkg::chroma_terms_t terms_r;
  y2r_pkg::chroma_terms_t terms_nxt;

  always_comb begin
    terms_nxt.red   = y2r_pkg::chroma_term(chroma_red, y2r_pkg::KC_RV, 1'b0);
    terms_nxt.green = y2r_pkg::chroma_term(chroma_blue, y2r_pkg::KC_GU, 1'b1) +
                      y2r_pkg::chroma_term(chroma_red, y2r_pkg::KC_GV, 1'b1);
    terms_nxt.blue  = y2r_pkg::chroma_term(chroma_blue, y2r_pkg::KC_BU, 1'b0);
  end

  always_ff @(posedge clk) begin
    terms_r <= terms_nxt;
  end

  assign terms = terms_r;

endmodule

`default_nettype wire

>>> design/y2r_lane.sv
// y2r_lane: one pixel lane, adds luma to the chroma terms, clamps and packs 5-6-5
// depends on y2r_pkg
`default_nettype none

module y2r_lane (
  input  wire logic [y2r_pkg::BYTE_W-1:0] luma,
  input  wire y2r_pkg::chroma_terms_t     terms,
  output logic [y2r_pkg::PIX_W-1:0]       pixel
);

  logic [y2r_pkg::BYTE_W-1:0] r_ch;
  logic [y2r_pkg::BYTE_W-1:0] g_ch;
  logic [y2r_pkg::BYTE_W-1:0] b_ch;

  function automatic logic [y2r_pkg::BYTE_W-1:0] clamp_sum(
      input logic [y2r_pkg::BYTE_W-1:0] y, input y2r_pkg::term_t t);
    logic signed [y2r_pkg::SUM_W-1:0] s;
    logic [y2r_pkg::BYTE_W-1:0]       c;
    s = $signed(y2r_pkg::SUM_W'(y)) + y2r_pkg::SUM_W'(t);
    if (s[y2r_pkg::SUM_W-1]) begin
      c = '0;
    end else if (s > $signed(y2r_pkg::SUM_W'(y2r_pkg::CHAN_MAX))) begin
      c = y2r_pkg::BYTE_W'(y2r_pkg::CHAN_MAX);
    end else begin
      c = s[y2r_pkg::BYTE_W-1:0];
    end
    return c;
  endfunction

  always_comb begin
    r_ch  = clamp_sum(luma, terms.red);
    g_ch  = clamp_sum(luma, terms.green);
    b_ch  = clamp_sum(luma, terms.blue);
    pixel = {r_ch[7:3], g_ch[7:2], b_ch[7:3]};
  end

endmodule

`default_nettype wire
